[src/hrf_pkg.sv]
// hrf_pkg: shared types, codes and size tables of the hid report fragmenter
// used by every module under src; depends on nothing
package hrf_pkg;

  // fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 11;
  localparam int unsigned RlenW  = 7;
  localparam int unsigned ChunkW = 6;
  localparam int unsigned SizeW  = 2;

  // command queue between front and back
  localparam int unsigned CmdQDepth = 2;

  localparam logic [ByteW-1:0] SyncByte = 8'hFF;
  localparam logic [ByteW-1:0] PadByte  = 8'h00;

  // link-control byte codes
  typedef enum logic [1:0] {
    LCB_SINGLE = 2'h0,
    LCB_LAST   = 2'h1,
    LCB_FIRST  = 2'h2,
    LCB_MIDDLE = 2'h3
  } lcb_e;

  // report size choices
  typedef enum logic [SizeW-1:0] {
    SZ_12 = 2'd0,
    SZ_14 = 2'd1,
    SZ_20 = 2'd2,
    SZ_63 = 2'd3
  } size_e;

  // configuration register indexes
  typedef enum logic {
    REG_LINK_ACTIVE = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_e;

  // back-end expansion phases
  typedef enum logic [3:0] {
    PH_ID   = 4'b0001,
    PH_LCB  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_PAD  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_start;
    logic [LenW-1:0]  frame_len;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [RlenW-1:0] report_len;
    logic             report_end;
    logic             frame_end;
    logic             last_of_run;
  } out_t;

  // one command per input byte that yields results
  typedef struct packed {
    logic              hdr;      // report id and link control go first
    lcb_e              lcb;
    logic [ByteW-1:0]  data;
    size_e             sz;
    logic              fin;      // last payload byte of the frame
    logic              full;     // data byte closes a full report
    logic [ChunkW-1:0] pads;     // zero pad bytes after the data byte
  } cmd_t;

  // report size in bytes
  function automatic logic [ChunkW-1:0] size_bytes(size_e sz);
    logic [ChunkW-1:0] s;
    unique case (sz)
      SZ_12:   s = 6'd12;
      SZ_14:   s = 6'd14;
      SZ_20:   s = 6'd20;
      SZ_63:   s = 6'd63;
      default: s = 6'd63;
    endcase
    return s;
  endfunction

endpackage

[src/hrf_front.sv]
// hrf_front: takes frame bytes, keeps the frame counters and issues one
// expansion command per byte that yields results; depends on hrf_pkg
module hrf_front #(
  parameter int unsigned FRAME_MAX = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           link_active_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hrf_pkg::in_t   in_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output hrf_pkg::cmd_t  cmd_o
);

  // saturation limit, bounded by what frame_len can carry
  localparam int unsigned FrameCap = (FRAME_MAX > 2047) ? 2047 : FRAME_MAX;

  logic [hrf_pkg::LenW-1:0]   rem_q, rem_d, rem_w, len_sat, len_adj, rem_n;
  logic [hrf_pkg::ChunkW-1:0] chunk_q, chunk_d, chunk_w, chunk_n, cap;
  logic                       aw_q, aw_d, aw_w;
  hrf_pkg::size_e             sz_q, sz_d, sz_w;
  logic                       go, is_sync, fire;

  assign in_ready_o = cmd_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_sync    = (in_i.data_byte == hrf_pkg::SyncByte);
  assign len_sat    = (in_i.frame_len > hrf_pkg::LenW'(FrameCap)) ?
                      hrf_pkg::LenW'(FrameCap) : in_i.frame_len;
  assign len_adj    = len_sat - {10'd0, is_sync};

  // classify the byte and work out the counters after it
  always_comb begin
    rem_w   = rem_q;
    chunk_w = chunk_q;
    aw_w    = aw_q;
    sz_w    = sz_q;
    go      = 1'b1;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    aw_d    = aw_q;
    sz_d    = sz_q;
    cap     = 6'd0;
    rem_n   = '0;
    chunk_n = '0;
    cmd_o   = '0;
    // frame start abandons any open frame
    if (in_i.frame_start) begin
      rem_w   = '0;
      chunk_w = '0;
      aw_w    = 1'b0;
      if (!link_active_i || len_sat == '0 || len_adj == '0) begin
        go = 1'b0;
      end else begin
        priority if (len_adj <= 11'd11) sz_w = hrf_pkg::SZ_12;
        else if (len_adj <= 11'd13)     sz_w = hrf_pkg::SZ_14;
        else if (len_adj <= 11'd19)     sz_w = hrf_pkg::SZ_20;
        else                            sz_w = hrf_pkg::SZ_63;
        rem_w = len_adj;
        aw_w  = 1'b1;
        if (is_sync) go = 1'b0;
      end
    end
    if (rem_w == '0) go = 1'b0;
    cap = hrf_pkg::size_bytes(sz_w) - 6'd1;
    // link gone at a report boundary drops the rest of the frame
    if (go && chunk_w == '0 && !link_active_i) begin
      go      = 1'b0;
      rem_w   = '0;
      chunk_w = '0;
      aw_w    = 1'b0;
    end
    rem_d   = rem_w;
    chunk_d = chunk_w;
    aw_d    = aw_w;
    sz_d    = sz_w;
    if (go) begin
      rem_n   = rem_w - 11'd1;
      chunk_n = chunk_w + 6'd1;
      cmd_o.hdr  = (chunk_w == '0);
      if (aw_w) begin
        cmd_o.lcb = (rem_w <= {5'd0, cap}) ? hrf_pkg::LCB_SINGLE : hrf_pkg::LCB_FIRST;
      end else begin
        cmd_o.lcb = (rem_w <= {5'd0, cap}) ? hrf_pkg::LCB_LAST : hrf_pkg::LCB_MIDDLE;
      end
      cmd_o.data = in_i.data_byte;
      cmd_o.sz   = sz_w;
      cmd_o.fin  = (rem_n == '0);
      cmd_o.full = (chunk_n >= cap);
      cmd_o.pads = (cmd_o.fin && chunk_n < cap) ? (cap - chunk_n) : '0;
      rem_d   = rem_n;
      aw_d    = 1'b0;
      chunk_d = (cmd_o.fin || cmd_o.full) ? '0 : chunk_n;
    end
  end

  assign cmd_valid_o = in_valid_i && go;

  // frame counters move on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      chunk_q <= '0;
      aw_q    <= 1'b0;
      sz_q    <= hrf_pkg::SZ_12;
    end else if (fire) begin
      rem_q   <= rem_d;
      chunk_q <= chunk_d;
      aw_q    <= aw_d;
      sz_q    <= sz_d;
    end
  end

endmodule

[src/hrf_cmd_fifo.sv]
// hrf_cmd_fifo: short command queue between front and back
// depends on hrf_pkg for the command type and depth
module hrf_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrf_pkg::cmd_t  push_data_i,
  output logic           not_full_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output hrf_pkg::cmd_t  pop_data_o
);

  localparam int unsigned PtrW = $clog2(hrf_pkg::CmdQDepth);
  localparam int unsigned CntW = $clog2(hrf_pkg::CmdQDepth + 1);

  hrf_pkg::cmd_t       mem_q [hrf_pkg::CmdQDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign not_full_o  = (cnt_q != CntW'(hrf_pkg::CmdQDepth));
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i && not_full_o) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && not_full_o) begin
        wr_q <= (wr_q == PtrW'(hrf_pkg::CmdQDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && not_empty_o) begin
        rd_q <= (rd_q == PtrW'(hrf_pkg::CmdQDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i && not_full_o) - CntW'(pop_i && not_empty_o);
    end
  end

endmodule

[src/hrf_back.sv]
// hrf_back: expands each command into report bytes, one transfer a cycle
// while the receiver is ready, behind an output register; depends on hrf_pkg
module hrf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  hrf_pkg::cmd_t  cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrf_pkg::out_t  out_o
);

  hrf_pkg::cmd_t              cur_q, cur_d;
  logic                       cur_valid_q, cur_valid_d;
  hrf_pkg::phase_e            phase_q, phase_d, phase_nx;
  logic [hrf_pkg::ChunkW-1:0] pad_q, pad_d;
  hrf_pkg::out_t              out_q, out_d, gen;
  logic                       out_valid_q, out_valid_d;
  logic                       adv, run_last;

  assign adv       = cur_valid_q && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = cmd_valid_i && (!cur_valid_q || (adv && run_last));

  // byte for the current phase
  always_comb begin
    gen            = '0;
    gen.report_len = {1'b0, hrf_pkg::size_bytes(cur_q.sz)} + 7'd1;
    run_last       = 1'b0;
    phase_nx       = phase_q;
    unique case (phase_q)
      hrf_pkg::PH_ID: begin
        gen.out_byte = {6'd0, cur_q.sz} + 8'd1;
        phase_nx     = hrf_pkg::PH_LCB;
      end
      hrf_pkg::PH_LCB: begin
        gen.out_byte = {6'd0, cur_q.lcb};
        phase_nx     = hrf_pkg::PH_DATA;
      end
      hrf_pkg::PH_DATA: begin
        gen.out_byte = cur_q.data;
        if (cur_q.fin && cur_q.pads != '0) begin
          phase_nx = hrf_pkg::PH_PAD;
        end else begin
          run_last       = 1'b1;
          gen.report_end = cur_q.fin || cur_q.full;
          gen.frame_end  = cur_q.fin;
        end
      end
      hrf_pkg::PH_PAD: begin
        gen.out_byte = hrf_pkg::PadByte;
        if (pad_q == 6'd1) begin
          run_last       = 1'b1;
          gen.report_end = 1'b1;
          gen.frame_end  = 1'b1;
        end
      end
      default: begin
        gen.out_byte = hrf_pkg::PadByte;
        run_last     = 1'b1;
      end
    endcase
    gen.last_of_run = run_last;
  end

  // command sequencing
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    pad_d       = pad_q;
    if (cmd_pop_o) begin
      cur_d       = cmd_i;
      cur_valid_d = 1'b1;
      phase_d     = cmd_i.hdr ? hrf_pkg::PH_ID : hrf_pkg::PH_DATA;
      pad_d       = cmd_i.pads;
    end else if (adv && run_last) begin
      cur_valid_d = 1'b0;
    end else if (adv) begin
      phase_d = phase_nx;
      if (phase_q == hrf_pkg::PH_PAD) pad_d = pad_q - 6'd1;
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_d       = gen;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= hrf_pkg::PH_DATA;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pad_q <= pad_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[src/hid_report_fragmenter.sv]
// hid_report_fragmenter: top level with the link register port
// depends on hrf_pkg, hrf_front, hrf_cmd_fifo and hrf_back
//
// Usage: frame bytes enter on the in channel (valid/ready), one per
// transfer; frame_start marks the first byte and carries frame_len. Report
// bytes leave on the out channel, each with its report length and end
// flags; last_of_run closes the transfers caused by one input byte.
// link_active is written through the APB port at address 0; frames are
// dropped while it is 0. pready is always high.
// Path: a byte that yields results passes the command queue, the current
// command register and the output register before its first transfer.
// Throughput: one transfer per cycle while the receiver is ready and a
// command waits, set by the back end that walks id, link control, data and
// pad bytes; an input byte yields up to 64 transfers via the 2-entry queue.
// Reset clears the link register, the frame counters, the queue and the
// output register. When the receiver stalls the output register holds,
// the queue fills and then in_ready_o drops.
module hid_report_fragmenter #(
  parameter int unsigned FRAME_MAX = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hrf_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrf_pkg::out_t  out_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic          link_active_q;
  logic          cmd_valid, cmd_ready, q_valid, q_pop;
  hrf_pkg::cmd_t cmd, q_cmd;
  hrf_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = hrf_pkg::reg_idx_e'(paddr[2]);
  assign prdata  = (reg_idx == hrf_pkg::REG_LINK_ACTIVE) ? {31'd0, link_active_q} : '0;

  // link register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_active_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == hrf_pkg::REG_LINK_ACTIVE) begin
      link_active_q <= pwdata[0];
    end
  end

  hrf_front #(
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .link_active_i (link_active_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  hrf_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_data_i (cmd),
    .not_full_o  (cmd_ready),
    .pop_i       (q_pop),
    .not_empty_o (q_valid),
    .pop_data_o  (q_cmd)
  );

  hrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[src/hrf_checker.sv]
// hrf_checker: port-level assertions for hid_report_fragmenter
// depends on hrf_pkg; bound to the top level below
module hrf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input hrf_pkg::out_t out_o,
  input logic          pready
);

  // a stalled transfer keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output changed while stalled");

  // frame end closes both the report and the run
  a_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.frame_end |-> out_o.report_end && out_o.last_of_run)
    else $error("frame end without report end or run end");

  // report length is one of the four sizes plus one
  a_rlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.report_len == 7'd13 || out_o.report_len == 7'd15 ||
                     out_o.report_len == 7'd21 || out_o.report_len == 7'd64))
    else $error("bad report length");

  // report length stays fixed inside a report
  a_rlen_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_o.report_end ##1 out_valid_o
    |-> out_o.report_len == $past(out_o.report_len) || $past(out_o.last_of_run))
    else $error("report length changed mid-report");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind hid_report_fragmenter hrf_checker u_hrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o),
  .pready      (pready)
);
